@@ design/rta_pkg.sv @@
// Shared types, constants and the sine table entry function of the rigid transform accumulator.
package rta_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ENTRY_W        = 32;
  localparam int DEPTH          = 12;
  localparam int ADDR_W         = 4;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_TRANSLATE = 3'd1,
    ACT_ROT_X     = 3'd2,
    ACT_ROT_Y     = 3'd3,
    ACT_ROT_Z     = 3'd4,
    ACT_DH        = 3'd5,
    ACT_APPLY     = 3'd6,
    ACT_NONE      = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLAN,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MUL,
    ST_WB,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_TRANS,
    OP_ROT,
    OP_APPLY
  } op_t;

  // Sine of m steps of the given size in radians, scaled by 2^frac.
  function automatic logic signed [ENTRY_W-1:0] quarter_sin(input int unsigned m,
                                                            input real step,
                                                            input int unsigned frac);
    real x;
    real v;
    x = step * real'(m);
    v = $sin(x) * (2.0 ** frac);
    return ENTRY_W'($rtoi(v + 0.5));
  endfunction

endpackage

@@ design/rta_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module rta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/rta_trig.sv @@
// Registered sine and cosine lookup from a quarter-wave table.
module rta_trig #(
  parameter int ANGLE_BITS = rta_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = rta_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [ANGLE_BITS-1:0]               angle,
  output logic signed [rta_pkg::ENTRY_W-1:0]  sin_q,
  output logic signed [rta_pkg::ENTRY_W-1:0]  cos_q
);
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int QW      = ANGLE_BITS - 2;
  localparam real STEP   = 1.5707963267948966 / QUARTER;

  logic signed [rta_pkg::ENTRY_W-1:0] tbl [QUARTER+1];
  logic [1:0]    q;
  logic [QW-1:0] r;
  logic [QW:0]   ri;
  logic [QW:0]   rc;
  logic signed [rta_pkg::ENTRY_W-1:0] s0;
  logic signed [rta_pkg::ENTRY_W-1:0] c0;

  for (genvar i = 0; i <= QUARTER; i++) begin : g_tbl
    assign tbl[i] = rta_pkg::quarter_sin(i, STEP, FRAC_BITS);
  end

  always_comb begin
    q  = angle[ANGLE_BITS-1 -: 2];
    r  = angle[QW-1:0];
    ri = {1'b0, r};
    rc = (QW+1)'(QUARTER) - ri;
    s0 = tbl[ri];
    c0 = tbl[rc];
  end

  always_ff @(posedge clk) begin
    unique case (q)
      2'd0: begin sin_q <= s0;  cos_q <= c0;  end
      2'd1: begin sin_q <= c0;  cos_q <= -s0; end
      2'd2: begin sin_q <= -s0; cos_q <= -c0; end
      default: begin sin_q <= -c0; cos_q <= s0; end
    endcase
  end
endmodule

@@ design/rta_mac.sv @@
// Shared multiply-accumulate unit with floor shift and 32-bit saturation.
module rta_mac #(
  parameter int FRAC_BITS = rta_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               clr,
  input  logic                               add_en,
  input  logic signed [rta_pkg::ENTRY_W-1:0] add_val,
  input  logic                               mul_en,
  input  logic signed [rta_pkg::ENTRY_W-1:0] a,
  input  logic signed [rta_pkg::ENTRY_W-1:0] b,
  output logic signed [rta_pkg::ENTRY_W-1:0] sat_out
);
  localparam int ACC_W = 66 - FRAC_BITS;
  logic signed [63:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term;

  always_comb begin
    prod = 64'(a) * 64'(b);
    term = ACC_W'(prod >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (mul_en) begin
      acc <= acc + term;
    end else if (add_en) begin
      acc <= acc + ACC_W'(add_val);
    end
  end

  always_comb begin
    if (acc > ACC_W'(64'sd2147483647)) begin
      sat_out = 32'sh7fffffff;
    end else if (acc < -ACC_W'(64'sd2147483648)) begin
      sat_out = 32'sh80000000;
    end else begin
      sat_out = acc[31:0];
    end
  end
endmodule

@@ design/rigid_transform_accumulator.sv @@
// Top level: rigid transform accumulator, matrix in RAM, one shared multiplier.
// An apply result stays valid until it is taken; no input is accepted until then.
// Throughput: one request at a time; the shared MAC and single RAM port set the pace.
// Reset: rst clears control, then a clear pass over every RAM entry writes identity into the RAM.
// Clear requests rerun that same pass.
module rigid_transform_accumulator #(
  parameter int ANGLE_BITS = rta_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = rta_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0], value_x[34:3], value_y[66:35], value_z[98:67],
  // angle_a[110:99], angle_b[122:111], zero pad
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic [95:0]  m_tdata
);
  localparam int W = rta_pkg::ENTRY_W;

  rta_pkg::state_t state, state_next;
  rta_pkg::action_t act;
  logic signed [W-1:0] vx, vy, vz;
  logic [ANGLE_BITS-1:0] ang_a, ang_b;
  logic [1:0] step;
  logic [1:0] row;
  logic [3:0] cnt;
  rta_pkg::op_t op;
  logic [1:0] cu, cv;
  logic signed [W-1:0] tv [4];
  logic signed [W-1:0] res_u;
  logic signed [W-1:0] px, py;
  logic [ANGLE_BITS-1:0] trig_ang;
  logic signed [W-1:0] s_q, c_q;

  logic we;
  logic [rta_pkg::ADDR_W-1:0] addr;
  logic [W-1:0] wdata, rdata;

  logic mclr, madd, mmul;
  logic signed [W-1:0] ma, mb, madd_v, msat;

  rta_ram #(.WIDTH(W), .DEPTH(rta_pkg::DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  rta_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_trig (
    .clk(clk), .angle(trig_ang), .sin_q(s_q), .cos_q(c_q)
  );

  rta_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mclr), .add_en(madd), .add_val(madd_v),
    .mul_en(mmul), .a(ma), .b(mb), .sat_out(msat)
  );

  // Sub-step plan: op, columns and operand vector for current step.
  logic signed [W-1:0] opx, opy, opz;
  logic last_step;
  always_comb begin
    op = rta_pkg::OP_TRANS; cu = 2'd0; cv = 2'd1;
    trig_ang = ang_a;
    opx = vx; opy = vy; opz = vz;
    last_step = 1'b1;
    unique case (act)
      rta_pkg::ACT_TRANSLATE: op = rta_pkg::OP_TRANS;
      rta_pkg::ACT_ROT_X: begin op = rta_pkg::OP_ROT; cu = 2'd1; cv = 2'd2; end
      rta_pkg::ACT_ROT_Y: begin op = rta_pkg::OP_ROT; cu = 2'd2; cv = 2'd0; end
      rta_pkg::ACT_ROT_Z: begin op = rta_pkg::OP_ROT; cu = 2'd0; cv = 2'd1; end
      rta_pkg::ACT_DH: begin
        last_step = (step == 2'd3);
        unique case (step)
          2'd0: begin op = rta_pkg::OP_TRANS; opy = '0; opz = '0; end
          2'd1: begin op = rta_pkg::OP_ROT; cu = 2'd1; cv = 2'd2; end
          2'd2: begin op = rta_pkg::OP_TRANS; opx = '0; opy = '0; end
          default: begin op = rta_pkg::OP_ROT; trig_ang = ang_b; end
        endcase
      end
      rta_pkg::ACT_APPLY: op = rta_pkg::OP_APPLY;
      default: op = rta_pkg::OP_TRANS;
    endcase
  end

  // cnt in ST_MUL sequences products; ST_WB writes results, or for apply captures the output point.
  always_comb begin
    state_next = state;
    we = 1'b0; addr = '0; wdata = '0;
    mclr = 1'b0; madd = 1'b0; mmul = 1'b0; madd_v = '0; ma = '0; mb = '0;
    s_tready = 1'b0;
    unique case (state)
      rta_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          priority if (s_tdata[2:0] == rta_pkg::ACT_CLEAR) begin
            state_next = rta_pkg::ST_CLEAR;
          end else if (s_tdata[2:0] == rta_pkg::ACT_NONE) begin
            state_next = rta_pkg::ST_IDLE;
          end else begin
            state_next = rta_pkg::ST_PLAN;
          end
        end
      end
      rta_pkg::ST_CLEAR: begin
        we = 1'b1; addr = cnt;
        wdata = (cnt == 4'd0 || cnt == 4'd5 || cnt == 4'd10) ? W'(1 << FRAC_BITS) : '0;
        if (cnt == 4'(rta_pkg::DEPTH - 1)) state_next = rta_pkg::ST_IDLE;
      end
      rta_pkg::ST_PLAN: begin
        addr = {row, 2'd0};
        state_next = rta_pkg::ST_RD0;
      end
      rta_pkg::ST_RD0: begin addr = {row, 2'd1}; state_next = rta_pkg::ST_RD1; end
      rta_pkg::ST_RD1: begin addr = {row, 2'd2}; state_next = rta_pkg::ST_RD2; end
      rta_pkg::ST_RD2: begin addr = {row, 2'd3}; state_next = rta_pkg::ST_RD3; end
      rta_pkg::ST_RD3: begin mclr = 1'b1; state_next = rta_pkg::ST_MUL; end
      rta_pkg::ST_MUL: begin
        if (op == rta_pkg::OP_ROT) begin
          unique case (cnt)
            4'd0: begin mmul = 1'b1; ma = c_q; mb = tv[cu]; end
            4'd1: begin mmul = 1'b1; ma = s_q; mb = tv[cv]; end
            4'd2: mclr = 1'b1;
            4'd3: begin mmul = 1'b1; ma = -s_q; mb = tv[cu]; end
            default: begin mmul = 1'b1; ma = c_q; mb = tv[cv]; end
          endcase
          if (cnt == 4'd4) state_next = rta_pkg::ST_WB;
        end else begin
          unique case (cnt)
            4'd0: begin madd = 1'b1; madd_v = tv[3]; end
            4'd1: begin mmul = 1'b1; ma = tv[0]; mb = opx; end
            4'd2: begin mmul = 1'b1; ma = tv[1]; mb = opy; end
            default: begin mmul = 1'b1; ma = tv[2]; mb = opz; end
          endcase
          if (cnt == 4'd3) state_next = rta_pkg::ST_WB;
        end
      end
      rta_pkg::ST_WB: begin
        if (op == rta_pkg::OP_ROT) begin
          we = 1'b1; addr = {row, cu}; wdata = res_u;
          if (cnt == 4'd1) begin
            addr = {row, cv}; wdata = msat; state_next = rta_pkg::ST_NEXT;
          end
        end else begin
          we = (op == rta_pkg::OP_TRANS); addr = {row, 2'd3}; wdata = msat;
          state_next = rta_pkg::ST_NEXT;
        end
      end
      rta_pkg::ST_NEXT: begin
        priority if (row != 2'd2) begin
          state_next = rta_pkg::ST_PLAN;
        end else if (op == rta_pkg::OP_APPLY) begin
          state_next = rta_pkg::ST_OUT;
        end else if (!last_step) begin
          state_next = rta_pkg::ST_PLAN;
        end else begin
          state_next = rta_pkg::ST_IDLE;
        end
      end
      rta_pkg::ST_OUT: if (m_tready) state_next = rta_pkg::ST_IDLE;
      default: state_next = rta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rta_pkg::ST_CLEAR;
      cnt   <= '0;
      row   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + 4'd1;
      if (state == rta_pkg::ST_IDLE) begin
        row <= '0; step <= '0;
      end else if (state == rta_pkg::ST_NEXT) begin
        if (row == 2'd2) begin row <= '0; step <= step + 2'd1; end
        else row <= row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rta_pkg::ST_IDLE && s_tvalid) begin
      act   <= rta_pkg::action_t'(s_tdata[2:0]);
      vx    <= s_tdata[34:3];
      vy    <= s_tdata[66:35];
      vz    <= s_tdata[98:67];
      ang_a <= ANGLE_BITS'(s_tdata[110:99]);
      ang_b <= ANGLE_BITS'(s_tdata[122:111]);
    end
    if (state == rta_pkg::ST_RD0) tv[0] <= rdata;
    if (state == rta_pkg::ST_RD1) tv[1] <= rdata;
    if (state == rta_pkg::ST_RD2) tv[2] <= rdata;
    if (state == rta_pkg::ST_RD3) tv[3] <= rdata;
    if (state == rta_pkg::ST_MUL && cnt == 4'd2) res_u <= msat;
    if (state == rta_pkg::ST_WB && op == rta_pkg::OP_APPLY) begin
      if (row == 2'd0) px <= msat;
      if (row == 2'd1) py <= msat;
      if (row == 2'd2) m_tdata <= {msat, py, px};
    end
  end

  assign m_tvalid = (state == rta_pkg::ST_OUT);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");
  a_no_write_apply: assert property (@(posedge clk) disable iff (rst)
    we |-> op != rta_pkg::OP_APPLY || state == rta_pkg::ST_CLEAR)
    else $error("apply wrote matrix");
endmodule
